// File: rtl/tcp_pkg.sv
`timescale 1ns / 1ps
package tcp_pkg;

    localparam int COORD_W  = 32;
    localparam int RAD_W    = 31;
    localparam int STATUS_W = 2;

    localparam logic [STATUS_W-1:0] ST_TWO       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOCONTACT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_COINC     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_OVF       = 2'd3;

    typedef struct packed {
        logic        [RAD_W-1:0]   new_radius;
        logic signed [COORD_W-1:0] first_center_x;
        logic signed [COORD_W-1:0] first_center_y;
        logic        [RAD_W-1:0]   first_radius;
        logic signed [COORD_W-1:0] second_center_x;
        logic signed [COORD_W-1:0] second_center_y;
        logic        [RAD_W-1:0]   second_radius;
    } t_tcp_in;

    typedef struct packed {
        logic        [STATUS_W-1:0] status;
        logic signed [COORD_W-1:0]  point_a_x;
        logic signed [COORD_W-1:0]  point_a_y;
        logic signed [COORD_W-1:0]  point_b_x;
        logic signed [COORD_W-1:0]  point_b_y;
    } t_tcp_out;

endpackage

// File: rtl/tcp_chan_if.sv
`timescale 1ns / 1ps
interface tcp_chan_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/tcp_mul.sv
`timescale 1ns / 1ps
module tcp_mul #(
    parameter int A_W    = 34,
    parameter int B_W    = 34,
    parameter int SIDE_W = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [A_W-1:0]       i_a,
    input  logic [B_W-1:0]       i_b,
    input  logic [SIDE_W-1:0]    i_side,
    output logic                 o_valid,
    output logic [A_W+B_W-1:0]   o_p,
    output logic [SIDE_W-1:0]    o_side
);
    localparam int AL = (A_W + 1) / 2;
    localparam int AH = A_W - AL;
    localparam int BL = (B_W + 1) / 2;
    localparam int BH = B_W - BL;
    localparam int PW = A_W + B_W;

    logic [AL+BL-1:0]  r_ll;
    logic [AL+BH-1:0]  r_lh;
    logic [AH+BL-1:0]  r_hl;
    logic [AH+BH-1:0]  r_hh;
    logic [PW-1:0]     r_s0;
    logic [PW-1:0]     r_s1;
    logic [PW-1:0]     n_s1;
    logic [PW-1:0]     r_p;
    logic [2:0]        r_v;
    logic [SIDE_W-1:0] r_side [3];

    // cross terms are shifted and summed in the same stage that packs the outer terms
    assign n_s1 = (PW'(r_lh) << BL) + (PW'(r_hl) << AL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ll      <= (AL+BL)'(i_a[AL-1:0])  * (AL+BL)'(i_b[BL-1:0]);
            r_lh      <= (AL+BH)'(i_a[AL-1:0])  * (AL+BH)'(i_b[B_W-1:BL]);
            r_hl      <= (AH+BL)'(i_a[A_W-1:AL]) * (AH+BL)'(i_b[BL-1:0]);
            r_hh      <= (AH+BH)'(i_a[A_W-1:AL]) * (AH+BH)'(i_b[B_W-1:BL]);
            r_s0      <= {r_hh, r_ll};
            r_s1      <= n_s1;
            r_p       <= r_s0 + r_s1;
            r_side[0] <= i_side;
            r_side[1] <= r_side[0];
            r_side[2] <= r_side[1];
        end
    end

    assign o_valid = r_v[2];
    assign o_p     = r_p;
    assign o_side  = r_side[2];
endmodule

// File: rtl/tcp_sqrt.sv
`timescale 1ns / 1ps
module tcp_sqrt #(
    parameter int IN_W   = 132,
    parameter int SIDE_W = 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic [IN_W-1:0]     i_rad,
    input  logic [SIDE_W-1:0]   i_side,
    output logic                o_valid,
    output logic [IN_W/2-1:0]   o_root,
    output logic [SIDE_W-1:0]   o_side
);
    localparam int RT_W = IN_W / 2;

    logic [IN_W-1:0]   r_op   [RT_W];
    logic [IN_W-1:0]   r_res  [RT_W];
    logic              r_v    [RT_W];
    logic [SIDE_W-1:0] r_side [RT_W];

    // one root bit per stage, msb first
    for (genvar k = 0; k < RT_W; k++) begin : g_step
        localparam logic [IN_W-1:0] ONE = IN_W'(1) << (IN_W - 2 - 2 * k);
        logic [IN_W-1:0]   w_op;
        logic [IN_W-1:0]   w_res;
        logic              w_v;
        logic [SIDE_W-1:0] w_side;
        logic [IN_W-1:0]   w_trial;
        logic [IN_W-1:0]   n_op;
        logic [IN_W-1:0]   n_res;

        if (k == 0) begin : g_first
            assign w_op   = i_rad;
            assign w_res  = '0;
            assign w_v    = i_valid;
            assign w_side = i_side;
        end else begin : g_next
            assign w_op   = r_op[k-1];
            assign w_res  = r_res[k-1];
            assign w_v    = r_v[k-1];
            assign w_side = r_side[k-1];
        end

        always_comb begin
            w_trial = w_res + ONE;
            if (w_op >= w_trial) begin
                n_op  = w_op - w_trial;
                n_res = (w_res >> 1) + ONE;
            end else begin
                n_op  = w_op;
                n_res = w_res >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_op[k]   <= n_op;
                r_res[k]  <= n_res;
                r_side[k] <= w_side;
            end
        end
    end

    assign o_valid = r_v[RT_W-1];
    assign o_root  = r_res[RT_W-1][RT_W-1:0];
    assign o_side  = r_side[RT_W-1];
endmodule

// File: rtl/tcp_div.sv
`timescale 1ns / 1ps
module tcp_div #(
    parameter int N_W    = 101,
    parameter int D_W    = 67,
    parameter int Q_W    = 35,
    parameter int LANES  = 4,
    parameter int SIDE_W = 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [LANES-1:0][N_W-1:0]   i_num,
    input  logic [D_W-1:0]              i_den,
    input  logic [SIDE_W-1:0]           i_side,
    output logic                        o_valid,
    output logic [LANES-1:0][Q_W-1:0]   o_quo,
    output logic [SIDE_W-1:0]           o_side
);
    localparam int WW = (N_W > D_W + Q_W) ? N_W : D_W + Q_W;

    logic [LANES-1:0][WW-1:0]  r_rem  [Q_W];
    logic [LANES-1:0][Q_W-1:0] r_quo  [Q_W];
    logic [D_W-1:0]            r_den  [Q_W];
    logic                      r_v    [Q_W];
    logic [SIDE_W-1:0]         r_side [Q_W];

    // restoring division, one quotient bit per stage; all lanes share the divisor
    for (genvar k = 0; k < Q_W; k++) begin : g_step
        localparam int B = Q_W - 1 - k;
        logic [LANES-1:0][WW-1:0]  w_rem;
        logic [LANES-1:0][Q_W-1:0] w_quo;
        logic [D_W-1:0]            w_den;
        logic                      w_v;
        logic [SIDE_W-1:0]         w_side;
        logic [WW-1:0]             w_trial;
        logic [LANES-1:0][WW-1:0]  n_rem;
        logic [LANES-1:0][Q_W-1:0] n_quo;

        if (k == 0) begin : g_first
            always_comb begin
                for (int l = 0; l < LANES; l++) begin
                    w_rem[l] = WW'(i_num[l]);
                end
            end
            assign w_quo  = '0;
            assign w_den  = i_den;
            assign w_v    = i_valid;
            assign w_side = i_side;
        end else begin : g_next
            assign w_rem  = r_rem[k-1];
            assign w_quo  = r_quo[k-1];
            assign w_den  = r_den[k-1];
            assign w_v    = r_v[k-1];
            assign w_side = r_side[k-1];
        end

        assign w_trial = WW'(w_den) << B;

        always_comb begin
            for (int l = 0; l < LANES; l++) begin
                if (w_rem[l] >= w_trial) begin
                    n_rem[l] = w_rem[l] - w_trial;
                    n_quo[l] = w_quo[l] | (Q_W'(1) << B);
                end else begin
                    n_rem[l] = w_rem[l];
                    n_quo[l] = w_quo[l];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_quo[k]  <= n_quo;
                r_den[k]  <= w_den;
                r_side[k] <= w_side;
            end
        end
    end

    assign o_valid = r_v[Q_W-1];
    assign o_quo   = r_quo[Q_W-1];
    assign o_side  = r_side[Q_W-1];
endmodule

// File: rtl/two_circle_tangent_placement.sv
`timescale 1ns / 1ps
// throughput: one beat per cycle unless the queue is full and the sink not ready; the root unit
// (2*W + 2 stages) and the divider (W + 3 stages) are fully pipelined, W = clamped COORD_WIDTH
// a two-entry output queue keeps input open while one result waits
// reset clears every valid bit and the queue; payload is not reset
module two_circle_tangent_placement #(
    parameter int COORD_WIDTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tcp_chan_if.sink   i_src,
    tcp_chan_if.source o_dst
);
    localparam int CW   = (COORD_WIDTH < 16) ? 16 : ((COORD_WIDTH > 32) ? 32 : COORD_WIDTH);
    localparam int DW   = CW + 1;
    localparam int SUMW = CW + 1;
    localparam int D2W  = 2 * DW;
    localparam int SQW  = 2 * SUMW;
    localparam int KW   = 2 * CW + 3;
    localparam int QIW  = 2 * SQW;
    localparam int RTW  = QIW / 2;
    localparam int KXW  = KW + DW;
    localparam int SXW  = RTW + DW;
    localparam int NW   = KXW + 1;
    localparam int DVW  = D2W + 1;
    localparam int QTW  = CW + 3;
    localparam int PW   = CW + 4;
    localparam int CSW  = CW + 5;

    typedef struct packed {
        logic kneg;
        logic dxneg;
        logic dyneg;
        logic offneg;
        logic coinc;
        logic nocontact;
    } t_flags;

    typedef struct packed {
        logic signed [CW-1:0] x1;
        logic signed [CW-1:0] y1;
        logic [D2W-1:0]       d2;
        logic [DW-1:0]        adx;
        logic [DW-1:0]        ady;
        t_flags               fl;
    } t_geo;

    typedef struct packed {
        t_geo           geo;
        logic [KXW-1:0] kmx;
        logic [KXW-1:0] kmy;
    } t_rt;

    typedef struct packed {
        logic signed [CW-1:0] x1;
        logic signed [CW-1:0] y1;
        t_flags               fl;
    } t_fin;

    logic en;
    logic push;
    logic pop;

    // stage 1: field extraction, center deltas, enlarged radii
    logic signed [CW-1:0] w_x1, w_y1, w_x2, w_y2;
    logic [CW-1:0]        w_nr;
    logic                 r_s1_v;
    logic signed [CW-1:0] r_s1_x1, r_s1_y1;
    logic signed [CW:0]   r_s1_dx, r_s1_dy;
    logic [CW-1:0]        r_s1_ra, r_s1_rb;

    assign w_x1 = signed'(i_src.data.first_center_x[CW-1:0]);
    assign w_y1 = signed'(i_src.data.first_center_y[CW-1:0]);
    assign w_x2 = signed'(i_src.data.second_center_x[CW-1:0]);
    assign w_y2 = signed'(i_src.data.second_center_y[CW-1:0]);
    assign w_nr = CW'(i_src.data.new_radius[CW-2:0]);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_x1 <= w_x1;
            r_s1_y1 <= w_y1;
            r_s1_dx <= (CW+1)'(w_x2) - (CW+1)'(w_x1);
            r_s1_dy <= (CW+1)'(w_y2) - (CW+1)'(w_y1);
            r_s1_ra <= CW'(i_src.data.first_radius[CW-2:0]) + w_nr;
            r_s1_rb <= CW'(i_src.data.second_radius[CW-2:0]) + w_nr;
        end
    end

    // stage 2: magnitudes and sign flags
    logic                 r_s2_v;
    logic signed [CW-1:0] r_s2_x1, r_s2_y1;
    logic [DW-1:0]        r_s2_adx, r_s2_ady;
    logic [SUMW-1:0]      r_s2_sum;
    logic [CW-1:0]        r_s2_dif, r_s2_ra, r_s2_rb;
    t_flags               r_s2_fl;
    t_flags               n_s2_fl;
    logic                 w_dxpos, w_dypos;

    always_comb begin
        w_dxpos           = !r_s1_dx[CW] && (r_s1_dx != '0);
        w_dypos           = !r_s1_dy[CW] && (r_s1_dy != '0);
        n_s2_fl           = '0;
        n_s2_fl.dxneg     = r_s1_dx[CW];
        n_s2_fl.dyneg     = r_s1_dy[CW];
        n_s2_fl.offneg    = (w_dxpos && w_dypos) || (r_s1_dx[CW] && r_s1_dy[CW]);
        n_s2_fl.coinc     = (r_s1_dx == '0) && (r_s1_dy == '0);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_x1  <= r_s1_x1;
            r_s2_y1  <= r_s1_y1;
            r_s2_adx <= r_s1_dx[CW] ? DW'(-r_s1_dx) : DW'(r_s1_dx);
            r_s2_ady <= r_s1_dy[CW] ? DW'(-r_s1_dy) : DW'(r_s1_dy);
            r_s2_sum <= SUMW'(r_s1_ra) + SUMW'(r_s1_rb);
            r_s2_dif <= (r_s1_ra > r_s1_rb) ? r_s1_ra - r_s1_rb : r_s1_rb - r_s1_ra;
            r_s2_ra  <= r_s1_ra;
            r_s2_rb  <= r_s1_rb;
            r_s2_fl  <= n_s2_fl;
        end
    end

    // stage 3: squares, one narrow multiplier each
    logic                 r_s3_v;
    logic signed [CW-1:0] r_s3_x1, r_s3_y1;
    logic [DW-1:0]        r_s3_adx, r_s3_ady;
    logic [D2W-1:0]       r_s3_dx2, r_s3_dy2;
    logic [SQW-1:0]       r_s3_s2;
    logic [2*CW-1:0]      r_s3_f2, r_s3_ra2, r_s3_rb2;
    t_flags               r_s3_fl;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s3_x1  <= r_s2_x1;
            r_s3_y1  <= r_s2_y1;
            r_s3_adx <= r_s2_adx;
            r_s3_ady <= r_s2_ady;
            r_s3_dx2 <= D2W'(r_s2_adx) * D2W'(r_s2_adx);
            r_s3_dy2 <= D2W'(r_s2_ady) * D2W'(r_s2_ady);
            r_s3_s2  <= SQW'(r_s2_sum) * SQW'(r_s2_sum);
            r_s3_f2  <= (2*CW)'(r_s2_dif) * (2*CW)'(r_s2_dif);
            r_s3_ra2 <= (2*CW)'(r_s2_ra) * (2*CW)'(r_s2_ra);
            r_s3_rb2 <= (2*CW)'(r_s2_rb) * (2*CW)'(r_s2_rb);
            r_s3_fl  <= r_s2_fl;
        end
    end

    // stage 4: squared center distance
    logic                 r_s4_v;
    logic signed [CW-1:0] r_s4_x1, r_s4_y1;
    logic [DW-1:0]        r_s4_adx, r_s4_ady;
    logic [D2W-1:0]       r_s4_d2;
    logic [SQW-1:0]       r_s4_s2;
    logic [2*CW-1:0]      r_s4_f2, r_s4_ra2, r_s4_rb2;
    t_flags               r_s4_fl;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s4_x1  <= r_s3_x1;
            r_s4_y1  <= r_s3_y1;
            r_s4_adx <= r_s3_adx;
            r_s4_ady <= r_s3_ady;
            r_s4_d2  <= r_s3_dx2 + r_s3_dy2;
            r_s4_s2  <= r_s3_s2;
            r_s4_f2  <= r_s3_f2;
            r_s4_ra2 <= r_s3_ra2;
            r_s4_rb2 <= r_s3_rb2;
            r_s4_fl  <= r_s3_fl;
        end
    end

    // stage 5: contact test, discriminant factors, K partial sum
    logic                 r_s5_v;
    logic signed [CW-1:0] r_s5_x1, r_s5_y1;
    logic [DW-1:0]        r_s5_adx, r_s5_ady;
    logic [D2W-1:0]       r_s5_d2;
    logic [SQW-1:0]       r_s5_fa, r_s5_fb;
    logic [KW-1:0]        r_s5_ksum;
    logic [2*CW-1:0]      r_s5_kn;
    t_flags               r_s5_fl;
    t_flags               n_s5_fl;
    logic                 w_noc;

    assign w_noc = (SQW'(r_s4_d2) > r_s4_s2) || (D2W'(r_s4_f2) > r_s4_d2);

    always_comb begin
        n_s5_fl           = r_s4_fl;
        n_s5_fl.nocontact = w_noc;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s5_x1   <= r_s4_x1;
            r_s5_y1   <= r_s4_y1;
            r_s5_adx  <= r_s4_adx;
            r_s5_ady  <= r_s4_ady;
            r_s5_d2   <= r_s4_d2;
            r_s5_fa   <= w_noc ? '0 : r_s4_s2 - SQW'(r_s4_d2);
            r_s5_fb   <= w_noc ? '0 : SQW'(r_s4_d2) - SQW'(r_s4_f2);
            r_s5_ksum <= KW'(r_s4_ra2) + KW'(r_s4_d2);
            r_s5_kn   <= r_s4_rb2;
            r_s5_fl   <= n_s5_fl;
        end
    end

    // stage 6: |K| and its sign
    logic                 r_s6_v;
    logic [SQW-1:0]       r_s6_fa, r_s6_fb;
    logic [KW-1:0]        r_s6_km;
    t_geo                 r_s6_geo;
    t_flags               n_s6_fl;
    logic                 w_kneg;

    assign w_kneg = r_s5_ksum < KW'(r_s5_kn);

    always_comb begin
        n_s6_fl      = r_s5_fl;
        n_s6_fl.kneg = w_kneg;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s6_fa      <= r_s5_fa;
            r_s6_fb      <= r_s5_fb;
            r_s6_km      <= w_kneg ? KW'(r_s5_kn) - r_s5_ksum : r_s5_ksum - KW'(r_s5_kn);
            r_s6_geo.x1  <= r_s5_x1;
            r_s6_geo.y1  <= r_s5_y1;
            r_s6_geo.d2  <= r_s5_d2;
            r_s6_geo.adx <= r_s5_adx;
            r_s6_geo.ady <= r_s5_ady;
            r_s6_geo.fl  <= n_s6_fl;
        end
    end

    // discriminant product and K-weighted deltas
    logic            w_mq_v;
    logic [QIW-1:0]  w_mq_p;
    t_geo            w_mq_geo;
    logic [KXW-1:0]  w_kmx, w_kmy;
    t_rt             w_rt_in;

    tcp_mul #(.A_W(SQW), .B_W(SQW), .SIDE_W($bits(t_geo))) u_mul_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s6_v),
        .i_a     (r_s6_fa),
        .i_b     (r_s6_fb),
        .i_side  (r_s6_geo),
        .o_valid (w_mq_v),
        .o_p     (w_mq_p),
        .o_side  (w_mq_geo)
    );

    tcp_mul #(.A_W(KW), .B_W(DW), .SIDE_W(1)) u_mul_kx (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s6_v),
        .i_a     (r_s6_km),
        .i_b     (r_s6_geo.adx),
        .i_side  (1'b0),
        .o_valid (),
        .o_p     (w_kmx),
        .o_side  ()
    );

    tcp_mul #(.A_W(KW), .B_W(DW), .SIDE_W(1)) u_mul_ky (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s6_v),
        .i_a     (r_s6_km),
        .i_b     (r_s6_geo.ady),
        .i_side  (1'b0),
        .o_valid (),
        .o_p     (w_kmy),
        .o_side  ()
    );

    assign w_rt_in.geo = w_mq_geo;
    assign w_rt_in.kmx = w_kmx;
    assign w_rt_in.kmy = w_kmy;

    logic            w_rt_v;
    logic [RTW-1:0]  w_root;
    t_rt             w_rt_out;

    tcp_sqrt #(.IN_W(QIW), .SIDE_W($bits(t_rt))) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (w_mq_v),
        .i_rad   (w_mq_p),
        .i_side  (w_rt_in),
        .o_valid (w_rt_v),
        .o_root  (w_root),
        .o_side  (w_rt_out)
    );

    // half-chord numerators
    logic            w_ms_v;
    logic [SXW-1:0]  w_sqy, w_sqx;
    t_rt             w_ms_rt;

    tcp_mul #(.A_W(RTW), .B_W(DW), .SIDE_W($bits(t_rt))) u_mul_sy (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (w_rt_v),
        .i_a     (w_root),
        .i_b     (w_rt_out.geo.ady),
        .i_side  (w_rt_out),
        .o_valid (w_ms_v),
        .o_p     (w_sqy),
        .o_side  (w_ms_rt)
    );

    tcp_mul #(.A_W(RTW), .B_W(DW), .SIDE_W(1)) u_mul_sx (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (w_rt_v),
        .i_a     (w_root),
        .i_b     (w_rt_out.geo.adx),
        .i_side  (1'b0),
        .o_valid (),
        .o_p     (w_sqx),
        .o_side  ()
    );

    // stage 7: rounding bias on numerators, divisor 2*D2
    logic                    r_s7_v;
    logic [3:0][NW-1:0]      r_s7_num;
    logic [DVW-1:0]          r_s7_den;
    t_fin                    r_s7_fin;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s7_num[0] <= NW'(w_ms_rt.kmx) + NW'(w_ms_rt.geo.d2);
            r_s7_num[1] <= NW'(w_ms_rt.kmy) + NW'(w_ms_rt.geo.d2);
            r_s7_num[2] <= NW'(w_sqy) + NW'(w_ms_rt.geo.d2);
            r_s7_num[3] <= NW'(w_sqx) + NW'(w_ms_rt.geo.d2);
            r_s7_den    <= {w_ms_rt.geo.d2, 1'b0};
            r_s7_fin.x1 <= w_ms_rt.geo.x1;
            r_s7_fin.y1 <= w_ms_rt.geo.y1;
            r_s7_fin.fl <= w_ms_rt.geo.fl;
        end
    end

    logic                 w_dv_v;
    logic [3:0][QTW-1:0]  w_quo;
    t_fin                 w_dv_fin;

    tcp_div #(.N_W(NW), .D_W(DVW), .Q_W(QTW), .LANES(4), .SIDE_W($bits(t_fin))) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s7_v),
        .i_num   (r_s7_num),
        .i_den   (r_s7_den),
        .i_side  (r_s7_fin),
        .o_valid (w_dv_v),
        .o_quo   (w_quo),
        .o_side  (w_dv_fin)
    );

    // stage 8: midpoint and signed offsets
    logic                 r_s8_v;
    logic signed [PW-1:0] r_s8_px, r_s8_py, r_s8_ox, r_s8_oy;
    logic                 r_s8_coinc, r_s8_noc;
    logic signed [PW-1:0] w_pxm, w_pym, w_oxm, w_oym;

    assign w_pxm = signed'(PW'(w_quo[0]));
    assign w_pym = signed'(PW'(w_quo[1]));
    assign w_oxm = signed'(PW'(w_quo[2]));
    assign w_oym = signed'(PW'(w_quo[3]));

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s8_px    <= PW'(w_dv_fin.x1)
                        + ((w_dv_fin.fl.kneg != w_dv_fin.fl.dxneg) ? -w_pxm : w_pxm);
            r_s8_py    <= PW'(w_dv_fin.y1)
                        + ((w_dv_fin.fl.kneg != w_dv_fin.fl.dyneg) ? -w_pym : w_pym);
            r_s8_ox    <= w_dv_fin.fl.offneg ? -w_oxm : w_oxm;
            r_s8_oy    <= w_oym;
            r_s8_coinc <= w_dv_fin.fl.coinc;
            r_s8_noc   <= w_dv_fin.fl.nocontact;
        end
    end

    // valid bits of the local stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
            r_s5_v <= 1'b0;
            r_s6_v <= 1'b0;
            r_s7_v <= 1'b0;
            r_s8_v <= 1'b0;
        end else if (en) begin
            r_s1_v <= i_src.valid;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
            r_s4_v <= r_s3_v;
            r_s5_v <= r_s4_v;
            r_s6_v <= r_s5_v;
            r_s7_v <= w_ms_v;
            r_s8_v <= w_dv_v;
        end
    end

    // final sums with saturation
    logic signed [CSW-1:0] w_c [4];
    logic signed [CW-1:0]  w_s [4];
    logic [3:0]            w_ov;
    tcp_pkg::t_tcp_out     n_entry;

    always_comb begin
        w_c[0] = CSW'(r_s8_px) + CSW'(r_s8_ox);
        w_c[1] = CSW'(r_s8_py) + CSW'(r_s8_oy);
        w_c[2] = CSW'(r_s8_px) - CSW'(r_s8_ox);
        w_c[3] = CSW'(r_s8_py) - CSW'(r_s8_oy);
        for (int i = 0; i < 4; i++) begin
            w_ov[i] = (w_c[i][CSW-1:CW-1] != '0) && (w_c[i][CSW-1:CW-1] != '1);
            if (w_ov[i]) begin
                w_s[i] = w_c[i][CSW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
            end else begin
                w_s[i] = w_c[i][CW-1:0];
            end
        end
        n_entry = '0;
        if (r_s8_coinc) begin
            n_entry.status = tcp_pkg::ST_COINC;
        end else if (r_s8_noc) begin
            n_entry.status = tcp_pkg::ST_NOCONTACT;
        end else begin
            n_entry.status    = (w_ov != '0) ? tcp_pkg::ST_OVF : tcp_pkg::ST_TWO;
            n_entry.point_a_x = tcp_pkg::COORD_W'(w_s[0]);
            n_entry.point_a_y = tcp_pkg::COORD_W'(w_s[1]);
            n_entry.point_b_x = tcp_pkg::COORD_W'(w_s[2]);
            n_entry.point_b_y = tcp_pkg::COORD_W'(w_s[3]);
        end
    end

    // two-entry output queue
    tcp_pkg::t_tcp_out r_q [2];
    logic [1:0]        r_count;
    logic              r_head;

    assign en          = (r_count != 2'd2) || o_dst.ready;
    assign push        = en && r_s8_v;
    assign pop         = o_dst.valid && o_dst.ready;
    assign i_src.ready = en;
    assign o_dst.valid = r_count != 2'd0;
    assign o_dst.data  = r_q[r_head];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
            r_head  <= 1'b0;
        end else begin
            r_count <= r_count + 2'(push) - 2'(pop);
            if (pop) begin
                r_head <= ~r_head;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_head ^ r_count[0]] <= n_entry;
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("output queue count out of range");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd2 && !o_dst.ready) |-> !i_src.ready)
        else $error("input open while queue full and blocked");

    a_push_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |=> o_dst.valid)
        else $error("pushed result not presented");

    a_special_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_dst.valid && (o_dst.data.status == tcp_pkg::ST_COINC
                      || o_dst.data.status == tcp_pkg::ST_NOCONTACT))
        |-> (o_dst.data.point_a_x == '0 && o_dst.data.point_a_y == '0
             && o_dst.data.point_b_x == '0 && o_dst.data.point_b_y == '0))
        else $error("nonzero coordinates on a no-point status");
endmodule
